/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/fdc_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the frame deframer.
package fdc_pkg;

    // Queue between parser and result stage
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Configuration register indexes
    localparam logic [1:0] CFG_SOF1   = 2'd0;
    localparam logic [1:0] CFG_SOF2   = 2'd1;
    localparam logic [1:0] CFG_MAXLEN = 2'd2;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_ACCEPT   = 2'd1,
        KIND_BAD_CRC  = 2'd2,
        KIND_TOO_LONG = 2'd3
    } t_kind;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SOF2  = 3'd1,
        PH_LENLO = 3'd2,
        PH_LENHI = 3'd3,
        PH_CMD   = 3'd4,
        PH_DATA  = 3'd5,
        PH_CRCLO = 3'd6,
        PH_CRCHI = 3'd7
    } t_phase;

    // Work for the result stage
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_CRC_INIT = 3'd1,
        OP_CRC_FEED = 3'd2,
        OP_PAYLOAD  = 3'd3,
        OP_CRC_LOW  = 3'd4,
        OP_VERDICT  = 3'd5
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [7:0]  command;
        logic [15:0] length;
        logic [15:0] index;
        logic        too_long;
    } t_item;

    // One byte through the CRC, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/fdc_front.sv */
// Front end: holds configuration, tracks frame phase and tags each byte with its work.
module fdc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_q_full,
    output logic                o_full,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_q_wr,
    output fdc_pkg::t_item      o_q_item
);

    fdc_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_len;
    logic [7:0]      r_cmd;
    logic [15:0]     r_count;
    logic [7:0]      r_sof1;
    logic [7:0]      r_sof2;
    logic [15:0]     r_max;

    logic            accept;
    logic            too_long;
    logic            last_data;
    fdc_pkg::t_op    op;

    assign o_full    = i_q_full;
    assign accept    = i_push && !i_q_full;
    assign too_long  = r_len > r_max;
    assign last_data = ({1'b0, r_count} + 17'd1) >= {1'b0, r_len};

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                fdc_pkg::PH_HUNT:  if (i_rx_byte == r_sof1) n_phase = fdc_pkg::PH_SOF2;
                fdc_pkg::PH_SOF2:  n_phase = (i_rx_byte == r_sof2) ? fdc_pkg::PH_LENLO
                                                                   : fdc_pkg::PH_HUNT;
                fdc_pkg::PH_LENLO: n_phase = fdc_pkg::PH_LENHI;
                fdc_pkg::PH_LENHI: n_phase = fdc_pkg::PH_CMD;
                fdc_pkg::PH_CMD:   n_phase = (r_len != 16'd0) ? fdc_pkg::PH_DATA
                                                              : fdc_pkg::PH_CRCLO;
                fdc_pkg::PH_DATA:  if (last_data) n_phase = fdc_pkg::PH_CRCLO;
                fdc_pkg::PH_CRCLO: n_phase = fdc_pkg::PH_CRCHI;
                fdc_pkg::PH_CRCHI: n_phase = fdc_pkg::PH_HUNT;
                default:           n_phase = fdc_pkg::PH_HUNT;
            endcase
        end
    end

    // Work tag for the current byte
    always_comb begin
        op = fdc_pkg::OP_NONE;
        unique case (r_phase)
            fdc_pkg::PH_HUNT:  op = fdc_pkg::OP_NONE;
            fdc_pkg::PH_SOF2:  op = (i_rx_byte == r_sof2) ? fdc_pkg::OP_CRC_INIT
                                                          : fdc_pkg::OP_NONE;
            fdc_pkg::PH_LENLO,
            fdc_pkg::PH_LENHI,
            fdc_pkg::PH_CMD:   op = fdc_pkg::OP_CRC_FEED;
            fdc_pkg::PH_DATA:  op = too_long ? fdc_pkg::OP_CRC_FEED : fdc_pkg::OP_PAYLOAD;
            fdc_pkg::PH_CRCLO: op = fdc_pkg::OP_CRC_LOW;
            fdc_pkg::PH_CRCHI: op = fdc_pkg::OP_VERDICT;
            default:           op = fdc_pkg::OP_NONE;
        endcase
    end

    assign o_q_wr            = accept && (op != fdc_pkg::OP_NONE);
    assign o_q_item.op       = op;
    assign o_q_item.data     = i_rx_byte;
    assign o_q_item.command  = r_cmd;
    assign o_q_item.length   = r_len;
    assign o_q_item.index    = r_count;
    assign o_q_item.too_long = too_long;

    // Phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fdc_pkg::PH_HUNT;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Header fields and payload counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= 16'd0;
            r_cmd   <= 8'd0;
            r_count <= 16'd0;
        end else if (accept) begin
            unique case (r_phase)
                fdc_pkg::PH_LENLO: r_len <= {8'd0, i_rx_byte};
                fdc_pkg::PH_LENHI: r_len[15:8] <= i_rx_byte;
                fdc_pkg::PH_CMD: begin
                    r_cmd   <= i_rx_byte;
                    r_count <= 16'd0;
                end
                fdc_pkg::PH_DATA:  r_count <= r_count + 16'd1;
                default: ;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof1 <= 8'hA5;
            r_sof2 <= 8'h5A;
            r_max  <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fdc_pkg::CFG_SOF1:   r_sof1 <= i_cfg_data[7:0];
                fdc_pkg::CFG_SOF2:   r_sof2 <= i_cfg_data[7:0];
                fdc_pkg::CFG_MAXLEN: r_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/fdc_fifo.sv */
// Short queue of tagged bytes between the parser and the result stage.
module fdc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  fdc_pkg::t_item      i_item,
    output logic                o_full,
    input  logic                i_rd,
    output logic                o_empty,
    output fdc_pkg::t_item      o_head
);

    fdc_pkg::t_item               r_slot [fdc_pkg::QDEPTH];
    logic [fdc_pkg::QAW-1:0]      r_wp;
    logic [fdc_pkg::QAW-1:0]      r_rp;
    logic [fdc_pkg::QCW-1:0]      r_cnt;
    logic                         wr_en;
    logic                         rd_en;

    assign o_full  = r_cnt == fdc_pkg::QCW'(fdc_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_slot[r_rp];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wp] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wp <= r_wp + 1'b1;
            if (rd_en) r_rp <= r_rp + 1'b1;
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/fdc_back.sv */
// Back end: runs the CRC, builds result words and holds them in the output register.
module fdc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  fdc_pkg::t_item      i_head,
    output logic                o_q_rd,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_command,
    output logic [15:0]         o_frame_length,
    output logic [15:0]         o_byte_index,
    output logic [7:0]          o_data_byte
);

    logic                r_valid;
    fdc_pkg::t_kind      r_kind;
    logic [7:0]          r_cmd;
    logic [15:0]         r_len;
    logic [15:0]         r_idx;
    logic [7:0]          r_data;
    logic [15:0]         r_crc;
    logic [7:0]          r_crc_lo;

    logic                has_result;
    logic                take;
    logic                emit;
    fdc_pkg::t_kind      verdict;

    assign has_result = (i_head.op == fdc_pkg::OP_PAYLOAD) ||
                        (i_head.op == fdc_pkg::OP_VERDICT);
    assign take       = !r_valid || pop;
    assign o_q_rd     = !i_q_empty && (!has_result || take);
    assign emit       = o_q_rd && has_result;

    // Frame verdict from the length limit and the received CRC
    always_comb begin
        if (i_head.too_long) begin
            verdict = fdc_pkg::KIND_TOO_LONG;
        end else if ({i_head.data, r_crc_lo} == r_crc) begin
            verdict = fdc_pkg::KIND_ACCEPT;
        end else begin
            verdict = fdc_pkg::KIND_BAD_CRC;
        end
    end

    // Running CRC and low CRC byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= fdc_pkg::CRC_INIT;
            r_crc_lo <= 8'd0;
        end else if (o_q_rd) begin
            unique case (i_head.op)
                fdc_pkg::OP_CRC_INIT: r_crc <= fdc_pkg::CRC_INIT;
                fdc_pkg::OP_CRC_FEED,
                fdc_pkg::OP_PAYLOAD:  r_crc <= fdc_pkg::crc_feed(r_crc, i_head.data);
                fdc_pkg::OP_CRC_LOW:  r_crc_lo <= i_head.data;
                default: ;
            endcase
        end
    end

    // Output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_cmd <= i_head.command;
            r_len <= i_head.length;
            if (i_head.op == fdc_pkg::OP_PAYLOAD) begin
                r_kind <= fdc_pkg::KIND_PAYLOAD;
                r_idx  <= i_head.index;
                r_data <= i_head.data;
            end else begin
                r_kind <= verdict;
                r_idx  <= 16'd0;
                r_data <= 8'd0;
            end
        end
    end

    assign empty          = !r_valid;
    assign o_kind         = r_kind;
    assign o_command      = r_cmd;
    assign o_frame_length = r_len;
    assign o_byte_index   = r_idx;
    assign o_data_byte    = r_data;

endmodule

/* rtl/core/frame_deframer_crc16.sv */
// Top level of the SOF/length framed deframer with CRC-16 check.
//
//  channel   dir  handshake            word
//  --------  ---  -------------------  ---------------------------------------------
//  rx        in   push / full          i_rx_byte
//  result    out  empty / pop          o_kind o_command o_frame_length o_byte_index
//                                      o_data_byte
//  config    in   i_cfg_we             i_cfg_index i_cfg_data
//
// One byte per cycle in and one result per cycle out when both sides keep moving.
// A payload byte or verdict is written into the 4-entry queue as its byte is taken,
// then loaded from the queue head into the output register that drives the result ports.
// full rises when the queue is full; the parser stalls only then.
// Reset is synchronous; the block is ready the cycle after i_rst_n goes high.
module frame_deframer_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_command,
    output logic [15:0] o_frame_length,
    output logic [15:0] o_byte_index,
    output logic [7:0]  o_data_byte,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic           q_wr;
    logic           q_full;
    logic           q_rd;
    logic           q_empty;
    fdc_pkg::t_item q_in;
    fdc_pkg::t_item q_head;

    // Parser
    fdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (q_full),
        .o_full      (full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_q_wr      (q_wr),
        .o_q_item    (q_in)
    );

    // Queue of tagged bytes
    fdc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // CRC and result stage
    fdc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (q_head),
        .o_q_rd         (q_rd),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_command      (o_command),
        .o_frame_length (o_frame_length),
        .o_byte_index   (o_byte_index),
        .o_data_byte    (o_data_byte)
    );

endmodule

/* rtl/core/fdc_checker.sv */
// Port-level checks on the deframer, bound to the top level.
`include "assert_macros.svh"

module fdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_command,
    input logic [15:0] o_frame_length,
    input logic [15:0] o_byte_index,
    input logic [7:0]  o_data_byte
);

    // Waiting result word holds until taken
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_kind) && $stable(o_command) && $stable(o_frame_length) && $stable(o_byte_index) && $stable(o_data_byte))

    // Verdicts carry zero index and data
    `ASSERT_IMPL(a_verdict_zero, i_clk, i_rst_n, !empty && (o_kind != fdc_pkg::KIND_PAYLOAD), (o_byte_index == 16'd0) && (o_data_byte == 8'd0))

    // Payload index stays inside the declared length
    `ASSERT_IMPL(a_index_range, i_clk, i_rst_n, !empty && (o_kind == fdc_pkg::KIND_PAYLOAD), o_byte_index < o_frame_length)

    // Back-to-back payload words count up by one
    `ASSERT_IMPL(a_index_step, i_clk, i_rst_n, (!empty && pop && (o_kind == fdc_pkg::KIND_PAYLOAD)) ##1 (!empty && (o_kind == fdc_pkg::KIND_PAYLOAD)), o_byte_index == ($past(o_byte_index) + 16'd1))

endmodule

bind frame_deframer_crc16 fdc_checker u_fdc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_kind         (o_kind),
    .o_command      (o_command),
    .o_frame_length (o_frame_length),
    .o_byte_index   (o_byte_index),
    .o_data_byte    (o_data_byte)
);

/* test/frame_deframer_crc16_test.sv */
// Self-checking testbench for the frame deframer: directed frames, then random traffic.
module frame_deframer_crc16_test;

    localparam logic [15:0] SEED16       = 16'hFFFF;
    localparam logic [15:0] POLY16       = 16'h1021;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          STALL_LIMIT  = 400;

    typedef logic [7:0] t_byte_q[$];

    typedef struct {
        fdc_pkg::t_kind kind;
        logic [7:0]     command;
        logic [15:0]    length;
        logic [15:0]    index;
        logic [7:0]     data;
    } t_deframe_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_rx_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  o_kind;
    logic [7:0]  o_command;
    logic [15:0] o_frame_length;
    logic [15:0] o_byte_index;
    logic [7:0]  o_data_byte;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // Predictor copy of the registers and parser state
    logic [7:0]      sof1      = 8'hA5;
    logic [7:0]      sof2      = 8'h5A;
    logic [15:0]     max_len   = 16'd256;
    fdc_pkg::t_phase ph        = fdc_pkg::PH_HUNT;
    logic [15:0]     hdr_len   = '0;
    logic [7:0]      hdr_cmd   = '0;
    logic [15:0]     pay_count = '0;
    logic [15:0]     crc_acc   = SEED16;
    logic [7:0]      crc_lo_rx = '0;

    t_deframe_word pending_words[$];

    bit          calm = 1'b0;
    int unsigned mismatches    = 0;
    int unsigned bytes_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned kind_count[4] = '{0, 0, 0, 0};
    int unsigned stall_cycles  = 0;

    frame_deframer_crc16 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_command      (o_command),
        .o_frame_length (o_frame_length),
        .o_byte_index   (o_byte_index),
        .o_data_byte    (o_data_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0} ^ (fb ? POLY16 : 16'h0000);
        end
        return r;
    endfunction

    // Advance the parser model by one byte and queue the word it produces
    function automatic void deframe_byte(input logic [7:0] b);
        t_deframe_word w;
        case (ph)
            fdc_pkg::PH_HUNT: begin
                if (b == sof1) ph = fdc_pkg::PH_SOF2;
            end
            fdc_pkg::PH_SOF2: begin
                if (b == sof2) begin
                    ph      = fdc_pkg::PH_LENLO;
                    crc_acc = SEED16;
                end else begin
                    ph = fdc_pkg::PH_HUNT;
                end
            end
            fdc_pkg::PH_LENLO: begin
                hdr_len = {8'h00, b};
                crc_acc = crc16_update(crc_acc, b);
                ph      = fdc_pkg::PH_LENHI;
            end
            fdc_pkg::PH_LENHI: begin
                hdr_len[15:8] = b;
                crc_acc       = crc16_update(crc_acc, b);
                ph            = fdc_pkg::PH_CMD;
            end
            fdc_pkg::PH_CMD: begin
                hdr_cmd   = b;
                crc_acc   = crc16_update(crc_acc, b);
                pay_count = '0;
                ph        = (hdr_len != 16'd0) ? fdc_pkg::PH_DATA : fdc_pkg::PH_CRCLO;
            end
            fdc_pkg::PH_DATA: begin
                crc_acc = crc16_update(crc_acc, b);
                if (hdr_len <= max_len) begin
                    w = '{fdc_pkg::KIND_PAYLOAD, hdr_cmd, hdr_len, pay_count, b};
                    pending_words.push_back(w);
                end
                if ({1'b0, pay_count} + 17'd1 >= {1'b0, hdr_len}) ph = fdc_pkg::PH_CRCLO;
                pay_count = pay_count + 16'd1;
            end
            fdc_pkg::PH_CRCLO: begin
                crc_lo_rx = b;
                ph        = fdc_pkg::PH_CRCHI;
            end
            default: begin
                // verdict: length limit wins over the CRC check
                if (hdr_len > max_len) w.kind = fdc_pkg::KIND_TOO_LONG;
                else if ({b, crc_lo_rx} == crc_acc) w.kind = fdc_pkg::KIND_ACCEPT;
                else w.kind = fdc_pkg::KIND_BAD_CRC;
                w.command = hdr_cmd;
                w.length  = hdr_len;
                w.index   = '0;
                w.data    = '0;
                pending_words.push_back(w);
                ph = fdc_pkg::PH_HUNT;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // Compare each popped word with the oldest expected one
    always @(posedge i_clk) begin : check_results
        t_deframe_word w;
        if (i_rst_n && pop && !empty) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual kind=%0d cmd=0x%0h len=%0d",
                         $time, o_kind, o_command, o_frame_length);
            end else begin
                w = pending_words.pop_front();
                check_field("kind", 16'(w.kind), 16'(o_kind));
                check_field("command", 16'(w.command), 16'(o_command));
                check_field("frame_length", w.length, o_frame_length);
                check_field("byte_index", w.index, o_byte_index);
                check_field("data_byte", 16'(w.data), 16'(o_data_byte));
                words_checked++;
                kind_count[o_kind]++;
            end
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, none in the quiet phase
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Send one byte, after a random gap outside the quiet phase, waiting while the block is full
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
        deframe_byte(b);
    endtask

    task automatic send_bytes(input t_byte_q q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    // Stop sending and let every expected word come out
    task automatic settle();
        push <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            fdc_pkg::CFG_SOF1:   sof1    = val[7:0];
            fdc_pkg::CFG_SOF2:   sof2    = val[7:0];
            fdc_pkg::CFG_MAXLEN: max_len = val;
            default:             ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Full frame with current start bytes; fill < 0 gives random payload
    function automatic t_byte_q build_frame(input logic [7:0] cmd, input int unsigned len,
                                            input int fill, input bit good_crc);
        t_byte_q     q;
        logic [15:0] c;
        logic [15:0] l;
        l = 16'(len);
        q = {sof1, sof2, l[7:0], l[15:8], cmd};
        for (int i = 0; i < len; i++) q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        c = SEED16;
        for (int i = 2; i < q.size(); i++) c = crc16_update(c, q[i]);
        if (!good_crc) c = c ^ (16'd1 << $urandom_range(0, 15));
        q.push_back(c[7:0]);
        q.push_back(c[15:8]);
        return q;
    endfunction

    task automatic send_frame(input logic [7:0] cmd, input int unsigned len, input int fill,
                              input bit good_crc);
        send_bytes(build_frame(cmd, len, fill, good_crc));
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == sof1) b = b + 8'd1;
        return b;
    endfunction

    // Finish whatever frame the parser is in, keeping declared lengths short
    task automatic resync();
        logic [7:0] b;
        while (ph != fdc_pkg::PH_HUNT) begin
            b = 8'($urandom);
            if (ph == fdc_pkg::PH_SOF2 && b == sof2) b = b ^ 8'h01;
            if (ph == fdc_pkg::PH_LENHI) b = 8'h00;
            send_byte(b);
        end
    endtask

    // Reset register values: payload extremes, empty payload, bad CRC
    task automatic test_reset_defaults();
        send_frame(8'h00, 3, 8'h00, 1'b1);
        send_frame(8'hFF, 2, 8'hFF, 1'b1);
        send_frame(8'h11, 0, -1, 1'b1);
        send_frame(8'h22, 4, -1, 1'b0);
    endtask

    // Start-byte hunt: wrong second byte, first byte repeated, back-to-back frames
    task automatic test_start_hunt();
        repeat (3) send_byte(noise_byte());
        send_byte(sof1);
        send_byte(8'h00);
        send_byte(sof1);
        send_byte(sof1);
        send_byte(sof2);
        send_frame(8'h5A, 2, -1, 1'b1);
        send_frame(8'h5B, 1, -1, 1'b1);
    endtask

    // Length limit at its boundary and at both extremes
    task automatic test_length_limit();
        send_frame(8'h33, 256, -1, 1'b1);
        send_frame(8'h34, 257, -1, 1'b1);
        settle();
        write_reg(fdc_pkg::CFG_MAXLEN, 16'd0);
        send_frame(8'h35, 0, -1, 1'b1);
        send_frame(8'h36, 1, -1, 1'b1);
        send_frame(8'h37, 2, -1, 1'b0);
        settle();
        write_reg(fdc_pkg::CFG_MAXLEN, 16'hFFFF);
        send_frame(8'h38, 5, -1, 1'b1);
    endtask

    // Limit lowered while a frame is half received
    task automatic test_limit_change_mid_frame();
        t_byte_q q;
        settle();
        write_reg(fdc_pkg::CFG_MAXLEN, 16'd256);
        q = build_frame(8'h42, 6, -1, 1'b1);
        for (int i = 0; i < 7; i++) send_byte(q[i]);
        settle();
        write_reg(fdc_pkg::CFG_MAXLEN, 16'd3);
        for (int i = 7; i < q.size(); i++) send_byte(q[i]);
        settle();
        write_reg(fdc_pkg::CFG_MAXLEN, 16'd256);
    endtask

    // Start byte extremes, equal start bytes, write to an unused index
    task automatic test_register_extremes();
        settle();
        write_reg(fdc_pkg::CFG_SOF1, 16'h0000);
        write_reg(fdc_pkg::CFG_SOF2, 16'h00FF);
        send_frame(8'h01, 3, -1, 1'b1);
        settle();
        write_reg(fdc_pkg::CFG_SOF1, 16'h00FF);
        write_reg(fdc_pkg::CFG_SOF2, 16'h0000);
        send_frame(8'h02, 2, -1, 1'b1);
        settle();
        write_reg(fdc_pkg::CFG_SOF1, 16'h003C);
        write_reg(fdc_pkg::CFG_SOF2, 16'h003C);
        send_frame(8'h03, 2, -1, 1'b1);
        settle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_frame(8'h04, 1, -1, 1'b1);
    endtask

    // Random configuration, then mostly good frames with some broken ones and noise
    task automatic test_random_traffic(input int unsigned budget, input bit quiet);
        int unsigned stop_at;
        int unsigned choice;
        int unsigned plen;
        int unsigned cut;
        t_byte_q     q;
        logic [7:0]  b;
        settle();
        calm = quiet;
        write_reg(fdc_pkg::CFG_SOF1, 16'($urandom_range(0, 255)));
        write_reg(fdc_pkg::CFG_SOF2, 16'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
            0:       write_reg(fdc_pkg::CFG_MAXLEN, 16'd0);
            1:       write_reg(fdc_pkg::CFG_MAXLEN, 16'hFFFF);
            2:       write_reg(fdc_pkg::CFG_MAXLEN, 16'($urandom_range(1, 12)));
            default: write_reg(fdc_pkg::CFG_MAXLEN, 16'd256);
        endcase
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            choice = $urandom_range(0, 99);
            plen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            if (choice < 70) begin
                send_frame(8'($urandom), plen, -1, 1'b1);
            end else if (choice < 80) begin
                send_frame(8'($urandom), plen, -1, 1'b0);
            end else if (choice < 87) begin
                repeat ($urandom_range(1, 6)) send_byte(noise_byte());
            end else if (choice < 93) begin
                // start byte followed by a wrong second byte
                b = ($urandom_range(0, 1) != 0) ? sof1 : 8'($urandom);
                if (b == sof2) b = b ^ 8'h01;
                send_byte(sof1);
                send_byte(b);
            end else begin
                // frame cut short inside its payload, then a new frame
                plen = $urandom_range(2, 12);
                cut  = $urandom_range(1, plen - 1);
                q = build_frame(8'($urandom), plen, -1, 1'b1);
                for (int i = 0; i < 5 + cut; i++) send_byte(q[i]);
                send_frame(8'($urandom), $urandom_range(0, 8), -1, 1'b1);
                resync();
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_rx_byte   <= 8'h00;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= fdc_pkg::CFG_SOF1;
        i_cfg_data  <= 16'h0000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_start_hunt();
        test_length_limit();
        test_limit_change_mid_frame();
        test_register_extremes();
        repeat (4) test_random_traffic(40, 1'b0);
        test_random_traffic(60, 1'b1);

        settle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes over directed and random frames; checked %0d words.",
                 bytes_sent, words_checked);
        $display("Payload %0d, accepted %0d, bad CRC %0d, too long %0d.",
                 kind_count[fdc_pkg::KIND_PAYLOAD], kind_count[fdc_pkg::KIND_ACCEPT],
                 kind_count[fdc_pkg::KIND_BAD_CRC], kind_count[fdc_pkg::KIND_TOO_LONG]);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
